@@ sv/sobm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobm_pkg
// Shared constants, types and the quarter-wave sine table of the
// oscillator bank mixer.
// ----------------------------------------------------------------------------
package sobm_pkg;

	// Bank and field sizes.
	localparam int NUM_OSC         = 128;
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int ROM_SIZE        = 1 << SINE_TABLE_BITS;
	localparam int OSC_IDX_W       = 7;
	localparam int TUNE_W          = 32;
	localparam int GAIN_W          = 16;
	localparam int SAMPLE_W        = 24;
	localparam int NUM_ACT_W       = 8;
	localparam int SCALE_W         = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;
	localparam int QDEPTH          = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ACTIVE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 1'd1;

	// Reset values of the registers.
	localparam logic [NUM_ACT_W-1:0] NUM_ACTIVE_RST   = 8'd100;
	localparam logic [SCALE_W-1:0]   OUTPUT_SCALE_RST = 16'd13107;

	// Command codes of an input word.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// pi in Q2.30.
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic {
		OP_LOAD,
		OP_TICK
	} op_t;

	// One queued word between front and back.
	typedef struct packed {
		op_t                  op;
		logic [OSC_IDX_W-1:0] idx;
		logic [TUNE_W-1:0]    tw;
		logic [GAIN_W-1:0]    gain;
	} entry_t;

	typedef logic [15:0] sine_rom_t [ROM_SIZE];

	// One table entry: odd Taylor series of sin in Q2.30, rounded to Q1.15.
	function automatic logic [15:0] rom_entry(input int unsigned i);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] s;
		logic [63:0] v;
		a    = (64'(2 * i + 1) * PI_Q30) >> (SINE_TABLE_BITS + 2);
		a2   = (a * a) >> 30;
		term = a;
		pos  = a;
		neg  = 64'd0;
		term = ((term * a2) >> 30) / 64'd6;
		neg  = neg + term;
		term = ((term * a2) >> 30) / 64'd20;
		pos  = pos + term;
		term = ((term * a2) >> 30) / 64'd42;
		neg  = neg + term;
		term = ((term * a2) >> 30) / 64'd72;
		pos  = pos + term;
		term = ((term * a2) >> 30) / 64'd110;
		neg  = neg + term;
		term = ((term * a2) >> 30) / 64'd156;
		pos  = pos + term;
		s    = (pos >= neg) ? (pos - neg) : 64'd0;
		v    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

	function automatic sine_rom_t build_rom();
		sine_rom_t r;
		for (int i = 0; i < ROM_SIZE; i++) begin
			r[i] = rom_entry(i);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

endpackage
`default_nettype wire

@@ sv/sine_oscillator_bank_mixer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sine_oscillator_bank_mixer
// Bank of phase-accumulator sine oscillators mixed into one audio sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry cmd, osc_index, tuning_word and gain under in_valid /
//   in_stall. A load word (cmd 0) writes one oscillator's tuning word and
//   gain and gives no result; a tick word (cmd 1) gives one output word
//   (sample, saturated) under out_valid / out_stall.
//   A two-word queue sits behind the input, so words are taken while the
//   back end is busy or a result waits to be collected.
//   For a tick, N being the active count clipped to 128, the back end
//   takes one oscillator a cycle through the store reads, the sine table,
//   the gain multiply and the accumulator, then scales and rounds the sum
//   (only the scale and round steps when N is zero). Ticks run one after
//   another: no word leaves the queue until the tick's result is written.
//   Reset clears all phases, tuning words and gains (per-entry valid bits,
//   no clearing pass) and sets num_active to 100, output_scale to 13107.
//   While out_stall is high the result holds; loads still proceed, a
//   further tick waits until the output register is free.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata. The
//   user must write it only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module sine_oscillator_bank_mixer (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [sobm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [sobm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  cmd,
	input  wire [sobm_pkg::OSC_IDX_W-1:0]        osc_index,
	input  wire [sobm_pkg::TUNE_W-1:0]           tuning_word,
	input  wire [sobm_pkg::GAIN_W-1:0]           gain,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [sobm_pkg::SAMPLE_W-1:0] sample,
	output logic                                 saturated
);
	import sobm_pkg::*;

	logic [NUM_ACT_W-1:0] num_active_q;
	logic [SCALE_W-1:0]   output_scale_q;
	logic                 q_valid;
	entry_t               q_entry;
	logic                 q_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_active_q   <= NUM_ACTIVE_RST;
			output_scale_q <= OUTPUT_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ACTIVE:   num_active_q   <= cfg_wdata[NUM_ACT_W-1:0];
				REG_OUTPUT_SCALE: output_scale_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	sobm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.osc_index   (osc_index),
		.tuning_word (tuning_word),
		.gain        (gain),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop)
	);

	sobm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.num_active   (num_active_q),
		.output_scale (output_scale_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.saturated    (saturated)
	);

endmodule
`default_nettype wire

@@ sv/sobm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobm_front
// Accepts input words, sorts them into loads and ticks, drops loads to
// entries outside the bank, and holds them in a short queue for the back.
// ----------------------------------------------------------------------------
module sobm_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            cmd,
	input  wire [sobm_pkg::OSC_IDX_W-1:0]  osc_index,
	input  wire [sobm_pkg::TUNE_W-1:0]     tuning_word,
	input  wire [sobm_pkg::GAIN_W-1:0]     gain,
	output logic                           q_valid,
	output sobm_pkg::entry_t               q_entry,
	input  wire                            q_pop
);
	import sobm_pkg::*;

	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	entry_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                accept;
	logic                push;
	entry_t              new_entry;

	// Classify the incoming word.
	always_comb begin
		new_entry.op   = (cmd == CMD_TICK) ? OP_TICK : OP_LOAD;
		new_entry.idx  = osc_index;
		new_entry.tw   = tuning_word;
		new_entry.gain = gain;
	end

	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;
	assign push     = accept &&
		((cmd == CMD_TICK) || ({1'b0, osc_index} < (OSC_IDX_W + 1)'(NUM_OSC)));
	assign q_valid  = (cnt_q != '0);
	assign q_entry  = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

@@ sv/sobm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobm_back
// Carries out queued words: a load writes one oscillator entry, a tick
// sweeps the active oscillators through a four-stage pipeline, then scales,
// rounds and saturates the sum into the output register.
// ----------------------------------------------------------------------------
module sobm_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  q_valid,
	input  wire sobm_pkg::entry_t                q_entry,
	output logic                                 q_pop,
	input  wire [sobm_pkg::NUM_ACT_W-1:0]        num_active,
	input  wire [sobm_pkg::SCALE_W-1:0]          output_scale,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [sobm_pkg::SAMPLE_W-1:0] sample,
	output logic                                 saturated
);
	import sobm_pkg::*;

	localparam int CNT_W   = $clog2(NUM_OSC + 1);
	localparam int PROD_W  = 34;
	localparam int ACC_W   = PROD_W + $clog2(NUM_OSC);
	localparam int MUL_W   = ACC_W + SCALE_W + 1;
	localparam int RND_W   = MUL_W - 20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_SCALE,
		ST_ROUND
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [CNT_W-1:0]                n_eff;
	logic                            issue;
	logic [OSC_IDX_W-1:0]            rd_addr;

	// Oscillator stores; reset contents come from the valid bits.
	logic [PHASE_BITS-1:0]           phase_mem [NUM_OSC];
	logic [TUNE_W+GAIN_W-1:0]        tg_mem    [NUM_OSC];
	logic [NUM_OSC-1:0]              ph_vld_q;
	logic [NUM_OSC-1:0]              tg_vld_q;

	logic                            v_s1;
	logic [OSC_IDX_W-1:0]            addr_s1;
	logic [PHASE_BITS-1:0]           ph_rd_s1;
	logic [TUNE_W+GAIN_W-1:0]        tg_rd_s1;
	logic                            ph_ok_s1;
	logic                            tg_ok_s1;
	logic [PHASE_BITS-1:0]           phase_s1;
	logic [TUNE_W-1:0]               tw_s1;
	logic [GAIN_W-1:0]               gain_s1;
	logic [1:0]                      quad_s1;
	logic [SINE_TABLE_BITS-1:0]      ridx_s1;

	logic                            v_s2;
	logic [15:0]                     rom_s2;
	logic                            neg_s2;
	logic [GAIN_W-1:0]               gain_s2;
	logic signed [16:0]              sine_s2;

	logic                            v_s3;
	logic signed [PROD_W-1:0]        prod_s3;

	logic signed [ACC_W-1:0]         acc_q;
	logic signed [MUL_W-1:0]         mul_q;
	logic signed [RND_W-1:0]         rnd;
	logic                            load_go;
	logic                            tick_go;
	logic                            out_vld_q;
	logic signed [SAMPLE_W-1:0]      sample_q;
	logic                            sat_q;

	// Active count, clipped to the bank size.
	always_comb begin
		if ({1'b0, num_active} > (NUM_ACT_W + 1)'(NUM_OSC)) begin
			n_eff = CNT_W'(NUM_OSC);
		end else begin
			n_eff = CNT_W'(num_active);
		end
	end

	assign load_go = (state_q == ST_IDLE) && q_valid && (q_entry.op == OP_LOAD);
	assign tick_go = (state_q == ST_IDLE) && q_valid && (q_entry.op == OP_TICK) &&
		(!out_vld_q || !out_stall);
	assign q_pop   = load_go || tick_go;
	assign issue   = (state_q == ST_SWEEP);
	assign rd_addr = cnt_q[OSC_IDX_W-1:0];

	// Tuning and gain store: written by loads, read by the sweep.
	always_ff @(posedge clk) begin
		if (load_go) begin
			tg_mem[q_entry.idx] <= {q_entry.tw, q_entry.gain};
		end
		tg_rd_s1 <= tg_mem[rd_addr];
	end

	// Phase store: read at issue, written back one stage later.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			phase_mem[addr_s1] <= phase_s1 + PHASE_BITS'(tw_s1);
		end
		ph_rd_s1 <= phase_mem[rd_addr];
	end

	// Stage 1: resolve unwritten entries and split the phase.
	always_comb begin
		phase_s1 = ph_ok_s1 ? ph_rd_s1 : '0;
		tw_s1    = tg_ok_s1 ? tg_rd_s1[TUNE_W+GAIN_W-1:GAIN_W] : '0;
		gain_s1  = tg_ok_s1 ? tg_rd_s1[GAIN_W-1:0] : '0;
		quad_s1  = phase_s1[PHASE_BITS-1 -: 2];
		ridx_s1  = phase_s1[PHASE_BITS-3 -: SINE_TABLE_BITS];
		if (quad_s1[0]) begin
			ridx_s1 = ~ridx_s1;
		end
	end

	// Stage 2: signed table value.
	assign sine_s2 = neg_s2 ? -$signed({1'b0, rom_s2}) : $signed({1'b0, rom_s2});

	// Valid bits of the stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_vld_q <= '0;
			tg_vld_q <= '0;
		end else begin
			if (v_s1) begin
				ph_vld_q[addr_s1] <= 1'b1;
			end
			if (load_go) begin
				tg_vld_q[q_entry.idx] <= 1'b1;
			end
		end
	end

	// Sweep pipeline payload.
	always_ff @(posedge clk) begin
		addr_s1  <= rd_addr;
		ph_ok_s1 <= ph_vld_q[rd_addr];
		tg_ok_s1 <= tg_vld_q[rd_addr];
		rom_s2   <= SINE_ROM[ridx_s1];
		neg_s2   <= quad_s1[1];
		gain_s2  <= gain_s1;
		prod_s3  <= PROD_W'(sine_s2 * $signed({1'b0, gain_s2}));
		mul_q    <= MUL_W'(acc_q * $signed({1'b0, output_scale}));
	end

	assign rnd = RND_W'((mul_q + MUL_W'(1 << 19)) >>> 20);

	// Sequencer, pipeline valids, accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			acc_q     <= '0;
			out_vld_q <= 1'b0;
			sample_q  <= '0;
			sat_q     <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				acc_q <= acc_q + ACC_W'(prod_s3);
			end
			if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick_go) begin
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= (n_eff == '0) ? ST_SCALE : ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q + 1'b1 == n_eff) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					out_vld_q <= 1'b1;
					if (rnd > RND_W'((1 << (SAMPLE_W - 1)) - 1)) begin
						sample_q <= SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
						sat_q    <= 1'b1;
					end else if (rnd < -RND_W'(1 << (SAMPLE_W - 1))) begin
						sample_q <= SAMPLE_W'(1 << (SAMPLE_W - 1));
						sat_q    <= 1'b1;
					end else begin
						sample_q <= rnd[SAMPLE_W-1:0];
						sat_q    <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign sample    = sample_q;
	assign saturated = sat_q;

`ifndef SYNTHESIS
	a_round_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (!out_vld_q || !out_stall))
		else $error("finished word would overwrite a waiting result");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("sweep pipeline busy while idle");
	a_scale_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |-> (!v_s2 && !v_s3))
		else $error("scaling started before the sum was complete");
`endif

endmodule
`default_nettype wire

@@ tb/sobm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobm_checker
// Watches the input, output and configuration ports of the oscillator bank
// mixer, keeps its own model of the bank and compares every output word
// with the sample that the model predicts for the matching tick.
// ----------------------------------------------------------------------------
module sobm_checker (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [sobm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [sobm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire                                  in_valid,
	input  wire                                  in_stall,
	input  wire                                  cmd,
	input  wire [sobm_pkg::OSC_IDX_W-1:0]        osc_index,
	input  wire [sobm_pkg::TUNE_W-1:0]           tuning_word,
	input  wire [sobm_pkg::GAIN_W-1:0]           gain,
	input  wire                                  out_valid,
	input  wire                                  out_stall,
	input  wire signed [sobm_pkg::SAMPLE_W-1:0]  sample,
	input  wire                                  saturated,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   ticks_checked,
	output int                                   clipped_seen
);
	import sobm_pkg::*;

	typedef struct {
		logic [SAMPLE_W-1:0] mix;
		logic                clip;
	} mix_word_t;

	// Model state of the bank.
	logic [PHASE_BITS-1:0] phase_acc [NUM_OSC];
	logic [TUNE_W-1:0]     step_word [NUM_OSC];
	logic [GAIN_W-1:0]     amp       [NUM_OSC];
	logic [15:0]           quarter_wave [ROM_SIZE];
	logic [NUM_ACT_W-1:0]  active_count;
	logic [SCALE_W-1:0]    master_scale;
	mix_word_t             mix_q [$];

	// Quarter-wave entry: Taylor series of sin in Q2.30, rounded to Q1.15.
	function automatic logic [15:0] quarter_wave_value(input int unsigned n);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned plus;
		longint unsigned minus;
		longint unsigned r;
		x     = (longint'(2 * n + 1) * 64'd3373259426) / (4 * ROM_SIZE);
		x2    = (x * x) >> 30;
		t     = x;
		plus  = x;
		minus = 0;
		for (int k = 1; k <= 6; k++) begin
			t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				minus += t;
			end else begin
				plus += t;
			end
		end
		r = (plus >= minus) ? plus - minus : 0;
		r = (r * 32767 + (64'd1 << 29)) >> 30;
		if (r > 32767) begin
			r = 32767;
		end
		return r[15:0];
	endfunction

	initial begin
		for (int n = 0; n < ROM_SIZE; n++) begin
			quarter_wave[n] = quarter_wave_value(n);
		end
	end

	// Signed sine of one phase, from the quarter-wave table.
	function automatic longint sine_at(input logic [PHASE_BITS-1:0] ph);
		logic [1:0]                 quad;
		logic [SINE_TABLE_BITS-1:0] pos;
		longint                     v;
		quad = ph[PHASE_BITS-1 -: 2];
		pos  = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
		if (quad[0]) begin
			pos = ~pos;
		end
		v = longint'(quarter_wave[pos]);
		return quad[1] ? -v : v;
	endfunction

	// Sum the active oscillators, advance their phases and scale the mix.
	function automatic mix_word_t mix_tick();
		mix_word_t w;
		int        n;
		longint    acc;
		longint    q;
		n   = (active_count > NUM_OSC) ? NUM_OSC : active_count;
		acc = 0;
		for (int k = 0; k < n; k++) begin
			acc += sine_at(phase_acc[k]) * longint'(amp[k]);
			phase_acc[k] = phase_acc[k] + step_word[k];
		end
		q = (acc * longint'(master_scale) + (64'sd1 <<< 19)) >>> 20;
		w.clip = 1'b0;
		if (q > 8388607) begin
			q      = 8388607;
			w.clip = 1'b1;
		end else if (q < -8388608) begin
			q      = -8388608;
			w.clip = 1'b1;
		end
		w.mix = q[SAMPLE_W-1:0];
		return w;
	endfunction

	// Track configuration, accepted input words and output words.
	always @(posedge clk or negedge arst_n) begin
		mix_word_t exp_w;
		if (!arst_n) begin
			for (int k = 0; k < NUM_OSC; k++) begin
				phase_acc[k] = '0;
				step_word[k] = '0;
				amp[k]       = '0;
			end
			active_count  = NUM_ACTIVE_RST;
			master_scale  = OUTPUT_SCALE_RST;
			mix_q.delete();
			fail_count    = 0;
			ticks_checked = 0;
			clipped_seen  = 0;
			pending       = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (mix_q.size() == 0) begin
					$display("%0t: output word with no tick waiting: sample %0d saturated %0b",
						$time, sample, saturated);
					fail_count++;
				end else begin
					exp_w = mix_q.pop_front();
					ticks_checked++;
					if (saturated) begin
						clipped_seen++;
					end
					if (sample !== exp_w.mix) begin
						$display("%0t: sample mismatch: expected %0d, actual %0d", $time,
							$signed(exp_w.mix), sample);
						fail_count++;
					end
					if (saturated !== exp_w.clip) begin
						$display("%0t: saturated mismatch: expected %0b, actual %0b",
							$time, exp_w.clip, saturated);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_TICK) begin
					mix_q.push_back(mix_tick());
				end else begin
					step_word[osc_index] = tuning_word;
					amp[osc_index]       = gain;
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_NUM_ACTIVE) begin
					active_count = cfg_wdata[NUM_ACT_W-1:0];
				end else if (cfg_index == REG_OUTPUT_SCALE) begin
					master_scale = cfg_wdata[SCALE_W-1:0];
				end
			end
			pending = mix_q.size();
		end
	end

endmodule

@@ tb/tb_sine_oscillator_bank_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_oscillator_bank_mixer
// Drives load and tick words into the oscillator bank mixer under several
// register settings, with random gaps and output stalls, and lets the
// checker compare every sample with its own model of the bank.
// ----------------------------------------------------------------------------
module tb_sine_oscillator_bank_mixer;
	import sobm_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 160;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic                   cmd;
	logic [OSC_IDX_W-1:0]   osc_index;
	logic [TUNE_W-1:0]      tuning_word;
	logic [GAIN_W-1:0]      gain;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic                   saturated;
	int                     fail_count;
	int                     pending;
	int                     ticks_checked;
	int                     clipped_seen;
	int                     idle_cycles = 0;
	bit                     calm;
	int                     bank_span;

	sine_oscillator_bank_mixer i_dut (.*);

	sobm_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random output stalls, switched off during the calm stretch.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 14);
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one input word and hold it until it is taken.
	task automatic send_word(input logic c, input logic [OSC_IDX_W-1:0] idx,
		input logic [TUNE_W-1:0] tw, input logic [GAIN_W-1:0] g);
		if (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		osc_index   <= idx;
		tuning_word <= tw;
		gain        <= g;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Let the bank drain completely before touching the registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random word: mostly loads into the active part of the bank,
	// interleaved with ticks.
	task automatic random_word();
		logic [TUNE_W-1:0]    tw;
		logic [OSC_IDX_W-1:0] idx;
		logic [GAIN_W-1:0]    g;
		int                   pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			tw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
		end else if (pick < 40) begin
			tw = $urandom_range(0, 1 << 22);
		end else begin
			tw = $urandom;
		end
		idx = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, bank_span - 1)) :
			7'($urandom);
		g   = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
		send_word(($urandom_range(0, 99) < 55) ? CMD_LOAD : CMD_TICK, idx, tw, g);
	endtask

	initial begin
		int unsigned act_set [6];
		int unsigned scale_set [6];
		act_set   = '{128, 1, 255, 0, 37, 100};
		scale_set = '{65535, 0, 13107, 40000, 1, 2000};
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		cmd         = CMD_LOAD;
		osc_index   = '0;
		tuning_word = '0;
		gain        = '0;
		calm        = 1'b0;
		bank_span   = 100;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at reset settings, then active counts 0 and 128: field
		// extremes, phase-keeping reloads, and a tick with all gains still zero.
		send_word(CMD_TICK, 7'd0, 32'd0, 16'd0);
		send_word(CMD_LOAD, 7'd0, 32'h4000_0000, 16'hFFFF);
		send_word(CMD_LOAD, 7'd127, 32'hFFFF_FFFF, 16'h0001);
		send_word(CMD_LOAD, 7'd1, 32'h0000_0000, 16'h0000);
		send_word(CMD_LOAD, 7'd2, 32'h0010_0000, 16'h1000);
		send_word(CMD_LOAD, 7'd99, 32'hAAAA_5555, 16'h5555);
		repeat (4) send_word(CMD_TICK, 7'd0, 32'd0, 16'd0);
		send_word(CMD_LOAD, 7'd0, 32'h8000_0000, 16'hAAAA);
		repeat (3) send_word(CMD_TICK, 7'd0, 32'd0, 16'd0);
		drain();
		write_reg(REG_NUM_ACTIVE, 16'd0);
		send_word(CMD_TICK, 7'd0, 32'd0, 16'd0);
		drain();
		write_reg(REG_NUM_ACTIVE, 16'hFF80);
		write_reg(REG_OUTPUT_SCALE, 16'hFFFF);
		for (int k = 0; k < 4; k++) begin
			send_word(CMD_LOAD, 7'(k + 3), 32'd0, 16'hFFFF);
		end
		repeat (2) send_word(CMD_TICK, 7'd0, 32'd0, 16'd0);
		drain();

		// Random phases, one register setting each; the third runs calm.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_NUM_ACTIVE,
				16'(($urandom_range(0, 255) << 8) | act_set[ph]));
			write_reg(REG_OUTPUT_SCALE, 16'(scale_set[ph]));
			bank_span = (act_set[ph] == 0) ? 1 : (act_set[ph] > 128 ? 128 : act_set[ph]);
			calm      = (ph == 2);
			repeat (190) random_word();
			calm = 1'b0;
			drain();
		end

		$display("Checked %0d samples, %0d of them clipped, over six register settings",
			ticks_checked, clipped_seen);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
